@@ hw/rtl/fcr_pkg.sv @@
// Shared types and constants for the fault code registry.
// No dependencies; compiled first.
package fcr_pkg;

  localparam int MAX_CODES_DEF = 32;
  localparam int CODE_W        = 16;
  localparam int SEV_W         = 3;
  localparam int TOTAL_W       = 6;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_RAISE    = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_QUERY    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

@@ hw/rtl/fcr_intf.sv @@
// Request and response channels of the fault code registry.
// Depends on fcr_pkg.
interface fcr_req_if;
  logic                        valid;
  logic                        ready;
  fcr_pkg::action_e            action;
  logic [fcr_pkg::CODE_W-1:0]  fault_code;
  logic [fcr_pkg::SEV_W-1:0]   severity_in;

  modport source (output valid, output action, output fault_code, output severity_in,
                  input ready);
  modport sink   (input valid, input action, input fault_code, input severity_in,
                  output ready);
endinterface

interface fcr_rsp_if;
  logic                         valid;
  logic                         ready;
  fcr_pkg::status_e             status;
  logic                         code_active;
  logic [fcr_pkg::TOTAL_W-1:0]  active_total;
  logic [fcr_pkg::SEV_W-1:0]    worst_severity;

  modport source (output valid, output status, output code_active, output active_total,
                  output worst_severity, input ready);
  modport sink   (input valid, input status, input code_active, input active_total,
                  input worst_severity, output ready);
endinterface

@@ hw/rtl/fcr_ctrl.sv @@
// Sequencer of the fault code registry: accept, scan, commit.
// Depends on fcr_pkg; drives the datapath through cmd_t, reads sts_t.
module fcr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fcr_pkg::cmd_t cmd_o,
  input  fcr_pkg::sts_t sts_i
);
  import fcr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold the result back until the output register is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.commit)     out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_vld_q || out_ready_i))
    else $error("result committed over an unread result");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN))
    else $error("accepted request did not start a scan");

  a_done_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.scan_done) |=> (state_q == S_COMMIT))
    else $error("finished scan did not move to commit");

endmodule

@@ hw/rtl/fcr_dp.sv @@
// Datapath of the fault code registry: entry memories, active flags,
// scan pipeline, accumulators and result register. Depends on fcr_pkg.
module fcr_dp #(
  parameter int MaxCodes = fcr_pkg::MAX_CODES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcr_pkg::cmd_t               cmd_i,
  output fcr_pkg::sts_t               sts_o,
  input  fcr_pkg::action_e            action_i,
  input  logic [fcr_pkg::CODE_W-1:0]  fault_code_i,
  input  logic [fcr_pkg::SEV_W-1:0]   severity_in_i,
  output fcr_pkg::status_e            status_o,
  output logic                        code_active_o,
  output logic [fcr_pkg::TOTAL_W-1:0] active_total_o,
  output logic [fcr_pkg::SEV_W-1:0]   worst_severity_o
);
  import fcr_pkg::*;

  localparam int CNT_W = $clog2(MaxCodes + 1);
  localparam int IDX_W = (MaxCodes > 1) ? $clog2(MaxCodes) : 1;
  localparam int TOT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  // entry stores, no reset; only entries below the fill count are read
  logic [CODE_W-1:0] code_mem [MaxCodes];
  logic [SEV_W-1:0]  sev_mem  [MaxCodes];
  logic [CODE_W-1:0] code_rd_q;
  logic [SEV_W-1:0]  sev_rd_q;

  logic [MaxCodes-1:0] flag_q, flag_d;
  logic [CNT_W-1:0]    used_q, used_d;

  // latched request
  action_e           act_q;
  logic [CODE_W-1:0] code_q;
  logic [SEV_W-1:0]  sev_q;

  // scan pipeline
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_en;

  // accumulators
  logic [TOT_W-1:0] tot_q, tot_d;
  logic [SEV_W-1:0] worst_q, worst_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             hit_flag_q, hit_flag_d;

  // result register
  status_e          res_status_q, res_status_d;
  logic             res_active_q, res_active_d;
  logic [TOTAL_W-1:0] res_total_q;
  logic [SEV_W-1:0] res_worst_q;

  logic hit_now, flag_now, eff_flag, full, wr_en;

  assign rd_en = cmd_i.scan && (rd_cnt_q < used_q);
  assign full  = (used_q >= CNT_W'(MaxCodes));
  assign sts_o.scan_done = (rd_cnt_q >= used_q) && !rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      code_rd_q <= code_mem[rd_cnt_q[IDX_W-1:0]];
      sev_rd_q  <= sev_mem[rd_cnt_q[IDX_W-1:0]];
    end
    if (wr_en) begin
      code_mem[used_q[IDX_W-1:0]] <= code_q;
      sev_mem[used_q[IDX_W-1:0]]  <= sev_q;
    end
  end

  // flag of the entry after this action, so one pass yields the summary
  always_comb begin
    hit_now  = (code_rd_q == code_q);
    flag_now = flag_q[rd_idx_q];
    eff_flag = flag_now;
    if (hit_now && act_q == ACT_RAISE) eff_flag = 1'b1;
    if (hit_now && act_q == ACT_CLEAR) eff_flag = 1'b0;
  end

  always_comb begin
    rd_cnt_d   = rd_cnt_q;
    rd_vld_d   = 1'b0;
    tot_d      = tot_q;
    worst_d    = worst_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_flag_d = hit_flag_q;
    if (cmd_i.start) begin
      rd_cnt_d = '0;
      tot_d    = '0;
      worst_d  = '0;
      hit_d    = 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_d = rd_en;
      if (rd_en) rd_cnt_d = rd_cnt_q + CNT_W'(1);
      if (rd_vld_q) begin
        if (eff_flag) begin
          tot_d = tot_q + TOT_W'(1);
          if (sev_rd_q > worst_q) worst_d = sev_rd_q;
        end
        if (hit_now) begin
          hit_d      = 1'b1;
          hit_idx_d  = rd_idx_q;
          hit_flag_d = flag_now;
        end
      end
    end
  end

  always_comb begin
    flag_d       = flag_q;
    used_d       = used_q;
    wr_en        = 1'b0;
    res_status_d = ST_OK;
    res_active_d = 1'b0;
    if (cmd_i.commit) begin
      case (act_q)
        ACT_REGISTER: begin
          if (hit_q)     res_status_d = ST_DUPLICATE;
          else if (full) res_status_d = ST_FULL;
          else begin
            wr_en  = 1'b1;
            used_d = used_q + CNT_W'(1);
          end
        end
        ACT_RAISE, ACT_CLEAR: begin
          if (hit_q) flag_d[hit_idx_q] = (act_q == ACT_RAISE);
          else       res_status_d = ST_UNKNOWN;
        end
        ACT_QUERY:   res_active_d = hit_q && hit_flag_q;
        default:     res_status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= '0;
      used_q     <= '0;
      rd_cnt_q   <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      flag_q     <= flag_d;
      used_q     <= used_d;
      rd_cnt_q   <= rd_cnt_d;
      rd_vld_q   <= rd_vld_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q  <= action_i;
      code_q <= fault_code_i;
      sev_q  <= severity_in_i;
    end
    if (rd_en) rd_idx_q <= rd_cnt_q[IDX_W-1:0];
    tot_q      <= tot_d;
    worst_q    <= worst_d;
    hit_idx_q  <= hit_idx_d;
    hit_flag_q <= hit_flag_d;
    if (cmd_i.commit) begin
      res_status_q <= res_status_d;
      res_active_q <= res_active_d;
      res_total_q  <= tot_q[TOTAL_W-1:0];
      res_worst_q  <= worst_q;
    end
  end

  assign status_o         = res_status_q;
  assign code_active_o    = res_active_q;
  assign active_total_o   = res_total_q;
  assign worst_severity_o = res_worst_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MaxCodes))
    else $error("fill count beyond table depth");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (tot_q <= TOT_W'(used_q)))
    else $error("active count exceeds registered entries");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && hit_q) |-> (CNT_W'(hit_idx_q) < used_q))
    else $error("matched entry lies beyond the fill count");

endmodule

@@ hw/rtl/fault_code_registry.sv @@
// Top level of the fault code registry: sequencer plus datapath.
// Depends on fcr_pkg, fcr_intf, fcr_ctrl and fcr_dp.
//
//   channel  dir  modport  payload
//   req_i    in   sink     action, fault_code, severity_in
//   rsp_o    out  source   status, code_active, active_total, worst_severity
//
// Each request is accepted, then scanned over the registered entries through the
// single read port of the entry memories and the scan pipeline, then committed;
// the next request is accepted only after that commit.
// Reset clears the active flags and the fill count at once; no clearing pass.
// A finished result waits in the output register while the next request is
// taken; that request holds in commit until the result has been taken.
module fault_code_registry #(
  parameter int MaxCodes = fcr_pkg::MAX_CODES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcr_req_if.sink   req_i,
  fcr_rsp_if.source rsp_o
);
  import fcr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fcr_dp #(
    .MaxCodes (MaxCodes)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (req_i.action),
    .fault_code_i     (req_i.fault_code),
    .severity_in_i    (req_i.severity_in),
    .status_o         (rsp_o.status),
    .code_active_o    (rsp_o.code_active),
    .active_total_o   (rsp_o.active_total),
    .worst_severity_o (rsp_o.worst_severity)
  );

endmodule

@@ test/fault_code_registry_tb.sv @@
// Testbench for fault_code_registry: directed and random requests, each checked against
// a behavioural copy of the code table kept in the bench.
// Depends on fcr_pkg, fcr_intf and the fault_code_registry RTL.
module fault_code_registry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcr_pkg::*;

  localparam int MaxEntries = MAX_CODES_DEF;
  localparam int HoldCycles = 300;
  localparam int DrainLimit = 20000;
  localparam int PrintLimit = 100;

  typedef struct packed {
    status_e              status;
    logic                 code_active;
    logic [TOTAL_W-1:0]   active_total;
    logic [SEV_W-1:0]     worst_severity;
  } rsp_t;

  logic clk;
  logic rst_n;

  fcr_req_if req_if ();
  fcr_rsp_if rsp_if ();

  fault_code_registry u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // bench copy of the registry
  logic [CODE_W-1:0] code_tab [MaxEntries];
  logic [SEV_W-1:0]  sev_tab  [MaxEntries];
  bit                act_tab  [MaxEntries];
  int                used_cnt = 0;

  rsp_t awaited_rsp_q [$];
  int   err_cnt  = 0;
  bit   no_gaps  = 1'b0;
  bit   hold_off = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("fault_code_registry test failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (err_cnt < PrintLimit) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int entry_of(logic [CODE_W-1:0] code);
    int idx;
    idx = MaxEntries;
    for (int i = used_cnt - 1; i >= 0; i--) begin
      if (code_tab[i] == code) idx = i;
    end
    return idx;
  endfunction

  // Applies one request to the bench table and returns the response it should give.
  function automatic rsp_t registry_update(action_e act, logic [CODE_W-1:0] code,
                                           logic [SEV_W-1:0] sev);
    rsp_t r;
    int   idx;
    idx = entry_of(code);
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_REGISTER: begin
        // duplicate wins over full
        if (idx < MaxEntries) begin
          r.status = ST_DUPLICATE;
        end else if (used_cnt >= MaxEntries) begin
          r.status = ST_FULL;
        end else begin
          code_tab[used_cnt] = code;
          sev_tab[used_cnt]  = sev;
          act_tab[used_cnt]  = 1'b0;
          used_cnt++;
        end
      end
      ACT_RAISE, ACT_CLEAR: begin
        if (idx < MaxEntries) act_tab[idx] = (act == ACT_RAISE);
        else r.status = ST_UNKNOWN;
      end
      default: begin
        r.code_active = (idx < MaxEntries) && act_tab[idx];
      end
    endcase
    for (int i = 0; i < used_cnt; i++) begin
      if (act_tab[i]) begin
        r.active_total++;
        if (sev_tab[i] > r.worst_severity) r.worst_severity = sev_tab[i];
      end
    end
    return r;
  endfunction

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off = 1'b0;
      end
      rsp_if.ready <= no_gaps || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsp_q.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_if.status, want.status));
        if (rsp_if.code_active !== want.code_active)
          report_mismatch($sformatf("code_active got %0b want %0b",
                                    rsp_if.code_active, want.code_active));
        if (rsp_if.active_total !== want.active_total)
          report_mismatch($sformatf("active_total got %0d want %0d",
                                    rsp_if.active_total, want.active_total));
        if (rsp_if.worst_severity !== want.worst_severity)
          report_mismatch($sformatf("worst_severity got %0d want %0d",
                                    rsp_if.worst_severity, want.worst_severity));
      end
    end
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic send_req(action_e act, logic [CODE_W-1:0] code, logic [SEV_W-1:0] sev);
    if (!no_gaps && $urandom_range(99) < 14) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.fault_code  <= code;
    req_if.severity_in <= sev;
    // ready only moves at a rising edge; its value mid-cycle holds for the next edge
    @(negedge clk);
    while (!req_if.ready) @(negedge clk);
    @(posedge clk);
    awaited_rsp_q.push_back(registry_update(act, code, sev));
  endtask

  // Mostly known codes; registrations mostly with fresh codes.
  task automatic send_random(int reg_pct, int raise_pct);
    action_e           act;
    logic [CODE_W-1:0] code;
    logic [SEV_W-1:0]  sev;
    int                r;
    r   = $urandom_range(99);
    sev = SEV_W'($urandom_range(7));
    if (used_cnt == 0 || $urandom_range(9) == 0) code = CODE_W'($urandom);
    else code = code_tab[$urandom_range(used_cnt - 1)];
    if (r < reg_pct) begin
      act = ACT_REGISTER;
      if ($urandom_range(3) != 0) code = CODE_W'($urandom);
    end else if (r < reg_pct + (100 - reg_pct) * 3 / 4) begin
      act = ($urandom_range(99) < raise_pct) ? ACT_RAISE : ACT_CLEAR;
    end else begin
      act = ACT_QUERY;
    end
    send_req(act, code, sev);
  endtask

  task automatic test_empty_table();
    send_req(ACT_QUERY, 16'h0000, 3'd0);
    send_req(ACT_RAISE, 16'hFFFF, 3'd7);
    send_req(ACT_CLEAR, 16'h1234, 3'd0);
  endtask

  task automatic test_register_flags();
    send_req(ACT_REGISTER, 16'h0000, 3'd0);
    send_req(ACT_REGISTER, 16'hFFFF, 3'd7);
    send_req(ACT_REGISTER, 16'h8001, 3'd3);
    send_req(ACT_REGISTER, 16'hFFFF, 3'd2);
    send_req(ACT_QUERY,    16'hFFFF, 3'd0);
    send_req(ACT_RAISE,    16'hFFFF, 3'd5);
    send_req(ACT_RAISE,    16'hFFFF, 3'd0);
    send_req(ACT_RAISE,    16'h0000, 3'd7);
    send_req(ACT_QUERY,    16'hFFFF, 3'd7);
    send_req(ACT_CLEAR,    16'hFFFF, 3'd0);
    send_req(ACT_CLEAR,    16'hFFFF, 3'd0);
    send_req(ACT_CLEAR,    16'h8001, 3'd0);
    send_req(ACT_RAISE,    16'h8001, 3'd0);
    send_req(ACT_QUERY,    16'h8001, 3'd0);
    send_req(ACT_RAISE,    16'h7777, 3'd0);
    send_req(ACT_QUERY,    16'h7777, 3'd0);
    send_req(ACT_CLEAR,    16'h0000, 3'd0);
  endtask

  task automatic test_random_fill();
    int guard;
    guard = 0;
    while (used_cnt < MaxEntries && guard < 400) begin
      send_random(35, 60);
      guard++;
    end
  endtask

  task automatic test_full_table();
    logic [CODE_W-1:0] code;
    do code = CODE_W'($urandom); while (entry_of(code) < MaxEntries);
    send_req(ACT_REGISTER, code, 3'd7);
    send_req(ACT_REGISTER, code_tab[0], 3'd1);
    send_req(ACT_RAISE, code, 3'd0);
    send_req(ACT_QUERY, code, 3'd0);
  endtask

  // Response side stalls for a long while; the block fills and stops taking requests.
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (16) send_random(5, 50);
  endtask

  // Bursts leaning towards raise, balanced, or towards clear, so the active count
  // swings between empty and all entries.
  task automatic test_random_mix();
    int raise_pct;
    for (int b = 0; b < 24; b++) begin
      case (b % 3)
        0:       raise_pct = 95;
        1:       raise_pct = 50;
        default: raise_pct = 5;
      endcase
      no_gaps = (b == 7);
      repeat (50) send_random(5, raise_pct);
    end
    no_gaps = 1'b0;
  endtask

  initial begin : main
    int waited;
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_QUERY;
    req_if.fault_code  <= '0;
    req_if.severity_in <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_register_flags();
    test_random_fill();
    test_full_table();
    test_backpressure();
    test_random_mix();

    req_if.valid <= 1'b0;
    waited = 0;
    while (awaited_rsp_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", awaited_rsp_q.size()));
    repeat (2 * MaxEntries + 10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("fault_code_registry test passed");
    end else begin
      $display("fault_code_registry test failed");
    end
    $finish;
  end

endmodule
